>>> design/smx_pkg.sv
// shared types and constants for the splitmix seed expander
package smx_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd1;

    localparam logic MODE_XORWOW  = 1'b0;
    localparam logic MODE_RANLUX  = 1'b1;

    localparam logic [3:0] LAST_IDX_XORWOW = 4'd2;
    localparam logic [3:0] LAST_IDX_RANLUX = 4'd8;

    localparam logic [1:0] GROUP_ONE = 2'd1;
    localparam logic [1:0] GROUP_TWO = 2'd2;

    localparam logic [63:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [63:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;

    typedef struct packed {
        logic        mode;
        logic [31:0] start;
        logic [31:0] event_number;
        logic [31:0] step_number;
    } t_entry;

    typedef struct packed {
        logic        valid;
        logic [3:0]  word_index;
        logic        last_word;
        logic [63:0] st;
    } t_draw;

endpackage

>>> design/smx_front.sv
// front end: configuration registers and capture of accepted items
module smx_front
    import smx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_start,
    input  logic                 i_full,
    input  logic [31:0]          i_event_number,
    input  logic [31:0]          i_track_number,
    input  logic [31:0]          i_step_number,
    output logic                 o_push,
    output t_entry               o_entry
);

    logic [31:0] r_seed;
    logic        r_mode;
    logic [31:0] n_seed;
    logic        n_mode;

    always_comb begin
        n_seed = r_seed;
        n_mode = r_mode;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEED: n_seed = i_cfg_data;
                CFG_MODE: n_mode = i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
            r_mode <= MODE_XORWOW;
        end else begin
            r_seed <= n_seed;
            r_mode <= n_mode;
        end
    end

    assign o_push                = i_start && !i_full;
    assign o_entry.mode          = r_mode;
    assign o_entry.start         = r_seed ^ i_track_number;
    assign o_entry.event_number  = i_event_number;
    assign o_entry.step_number   = i_step_number;

endmodule

>>> design/smx_fifo.sv
// two-entry queue between front end and draw sequencer
module smx_fifo
    import smx_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_entry
);

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_entry = r_mem[r_rp];

endmodule

>>> design/smx_seq.sv
// back end sequencer: steps the splitmix state, one draw per cycle
module smx_seq
    import smx_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_q_valid,
    input  t_entry i_q_entry,
    output logic   o_pop,
    output t_draw  o_draw
);

    logic        r_active;
    logic        r_mode;
    logic [1:0]  r_grp;
    logic [1:0]  r_k;
    logic [3:0]  r_idx;
    logic [63:0] r_st;
    logic [31:0] r_event;
    logic [31:0] r_step;

    logic        n_active;
    logic        n_mode;
    logic [1:0]  n_grp;
    logic [1:0]  n_k;
    logic [3:0]  n_idx;
    logic [63:0] n_st;
    logic [31:0] n_event;
    logic [31:0] n_step;

    logic [3:0]  last_idx;
    logic [1:0]  last_k;
    logic        last_draw;
    logic [1:0]  adv_k;
    logic [1:0]  adv_grp;
    logic [63:0] mix;

    assign last_idx  = (r_mode == MODE_RANLUX) ? LAST_IDX_RANLUX : LAST_IDX_XORWOW;
    assign last_k    = (r_mode == MODE_RANLUX) ? 2'd2 : 2'd0;
    assign last_draw = r_active && (r_idx == last_idx);
    assign o_pop     = i_q_valid && (!r_active || last_draw);

    always_comb begin
        adv_k   = r_k + 2'd1;
        adv_grp = r_grp;
        if (r_k == last_k) begin
            adv_k   = 2'd0;
            adv_grp = r_grp + 2'd1;
        end
        mix = '0;
        if (adv_k == 2'd0) begin
            if (adv_grp == GROUP_ONE) begin
                mix = {32'd0, r_event};
            end else if (adv_grp == GROUP_TWO) begin
                mix = {32'd0, r_step};
            end
        end
    end

    always_comb begin
        n_active = r_active;
        n_mode   = r_mode;
        n_grp    = r_grp;
        n_k      = r_k;
        n_idx    = r_idx;
        n_st     = r_st;
        n_event  = r_event;
        n_step   = r_step;
        if (o_pop) begin
            n_active = 1'b1;
            n_mode   = i_q_entry.mode;
            n_grp    = 2'd0;
            n_k      = 2'd0;
            n_idx    = 4'd0;
            n_st     = {32'd0, i_q_entry.start} + GOLDEN_GAMMA;
            n_event  = i_q_entry.event_number;
            n_step   = i_q_entry.step_number;
        end else if (r_active && !last_draw) begin
            n_grp = adv_grp;
            n_k   = adv_k;
            n_idx = r_idx + 4'd1;
            n_st  = (r_st ^ mix) + GOLDEN_GAMMA;
        end else begin
            n_active = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_grp   <= n_grp;
        r_k     <= n_k;
        r_idx   <= n_idx;
        r_st    <= n_st;
        r_event <= n_event;
        r_step  <= n_step;
    end

    assign o_draw.valid      = r_active;
    assign o_draw.word_index = r_idx;
    assign o_draw.last_word  = last_draw;
    assign o_draw.st         = r_st;

endmodule

>>> design/smx_mix.sv
// back end finalizer: three-stage pipeline of the splitmix output mix
module smx_mix
    import smx_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_draw i_draw,
    output t_draw o_draw
);

    logic        r1_valid;
    logic [3:0]  r1_idx;
    logic        r1_last;
    logic [63:0] r1_ll;
    logic [31:0] r1_lh;
    logic [31:0] r1_hl;

    logic        r2_valid;
    logic [3:0]  r2_idx;
    logic        r2_last;
    logic [63:0] r2_ll;
    logic [31:0] r2_lh;
    logic [31:0] r2_hl;

    logic        r3_valid;
    logic [3:0]  r3_idx;
    logic        r3_last;
    logic [63:0] r3_word;

    logic [63:0] z;
    logic [63:0] y;
    logic [63:0] y2;
    logic [63:0] w;

    // z * mul_a modulo 2^64 from three 32x32 partial products
    assign z = i_draw.st ^ (i_draw.st >> 30);
    assign y = r1_ll + {r1_lh + r1_hl, 32'd0};
    assign y2 = y ^ (y >> 27);
    assign w = r2_ll + {r2_lh + r2_hl, 32'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_draw.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_idx  <= i_draw.word_index;
        r1_last <= i_draw.last_word;
        r1_ll   <= {32'd0, z[31:0]} * {32'd0, MIX_MUL_A[31:0]};
        r1_lh   <= z[31:0] * MIX_MUL_A[63:32];
        r1_hl   <= z[63:32] * MIX_MUL_A[31:0];

        r2_idx  <= r1_idx;
        r2_last <= r1_last;
        r2_ll   <= {32'd0, y2[31:0]} * {32'd0, MIX_MUL_B[31:0]};
        r2_lh   <= y2[31:0] * MIX_MUL_B[63:32];
        r2_hl   <= y2[63:32] * MIX_MUL_B[31:0];

        r3_idx  <= r2_idx;
        r3_last <= r2_last;
        r3_word <= w ^ (w >> 31);
    end

    assign o_draw.valid      = r3_valid;
    assign o_draw.word_index = r3_idx;
    assign o_draw.last_word  = r3_last;
    assign o_draw.st         = r3_word;

endmodule

>>> design/splitmix_rng_seed_expander.sv
// top level of the splitmix seed expander
// Each accepted item (start high while busy low) yields three 64-bit draws in
// xorwow mode or nine in ranlux++ mode, one draw per cycle from a single
// state-stepping sequencer, and items follow each other with no gap. An
// accepted item passes through the queue, the sequencer and the three mix
// stages before its first draw appears; the draws of one item come out on
// consecutive cycles, each marked by o_valid for one cycle; results cannot be
// held off. A two-item queue sits in front of the sequencer, and busy is high
// only while it is full. Configuration (index 0 seed, index 1 mode) is always
// ready and should be written only while no item is in flight.
module splitmix_rng_seed_expander
    import smx_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [31:0]          i_event_number,
    input  logic [31:0]          i_track_number,
    input  logic [31:0]          i_step_number,
    output logic                 o_valid,
    output logic [3:0]           o_word_index,
    output logic [63:0]          o_state_word,
    output logic                 o_last_word
);

    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_valid;
    t_entry f_entry;
    t_entry q_entry;
    t_draw  seq_draw;
    t_draw  out_draw;

    assign o_cfg_ready = 1'b1;

    smx_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .i_full         (q_full),
        .i_event_number (i_event_number),
        .i_track_number (i_track_number),
        .i_step_number  (i_step_number),
        .o_push         (push),
        .o_entry        (f_entry)
    );

    smx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    smx_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .o_pop     (pop),
        .o_draw    (seq_draw)
    );

    smx_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_draw  (seq_draw),
        .o_draw  (out_draw)
    );

    assign o_busy       = q_full;
    assign o_valid      = out_draw.valid;
    assign o_word_index = out_draw.word_index;
    assign o_state_word = out_draw.st;
    assign o_last_word  = out_draw.last_word;

endmodule

>>> design/smx_chk.sv
// port-level checker for the splitmix seed expander, with its bind
module smx_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic [3:0]  o_word_index,
    input logic        o_last_word
);

    a_draws_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_word |=> o_valid)
        else $error("draws of one transaction not contiguous");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_word |=> o_word_index == $past(o_word_index) + 4'd1)
        else $error("word index did not advance by one");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_word |-> o_word_index == 4'd2 || o_word_index == 4'd8)
        else $error("last word at unexpected index");

    a_restart_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_word |=> !o_valid || o_word_index == 4'd0)
        else $error("new transaction does not start at index zero");

endmodule

bind splitmix_rng_seed_expander smx_chk u_smx_chk (.*);
